>>> rtl/core/conv2d_8x8_valid_core_macros.svh
// Assertion macros for the checker of the 8x8 convolution core.
// No dependencies; included by the checker file of the core.
`ifndef CONV2D_8X8_VALID_CORE_MACROS_SVH
`define CONV2D_8X8_VALID_CORE_MACROS_SVH

// Concurrent check on a named clock and active-low reset.
`define C2D_CHECK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Concurrent check on the core's own clock and reset.
`define C2D_CHECK_CORE(label, prop, msg) `C2D_CHECK(label, clk, arst_n, prop, msg)

`endif

>>> rtl/core/conv2d_pkg.sv
// Shared types and constants of the 8x8 valid-region convolution core.
// No dependencies; imported by every module of the core.
package conv2d_pkg;

	localparam int VAL_W           = 16;
	localparam int PROD_W          = 2 * VAL_W;
	localparam int RES_W           = 38;
	localparam int POS_W           = 10;
	localparam int SIZE_W          = 11;
	localparam int IDX_W           = 6;
	localparam int MAX_SIZE_DEF    = 1024;
	localparam int KERNEL_SIZE_DEF = 8;
	localparam int KTAPS_DEF       = KERNEL_SIZE_DEF * KERNEL_SIZE_DEF;
	localparam int IMG_SIZE_RST    = 64;

	// Item kinds on the op field.
	localparam logic OP_COEF  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Per-cell control: window shift, coefficient write and its data.
	typedef struct packed {
		logic                    shift;
		logic                    coef_we;
		logic signed [VAL_W-1:0] coef;
	} cell_ctl_t;

	// Position and framing that travel alongside the adder tree.
	typedef struct packed {
		logic             emit;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} tag_t;

	// One finished result as held in the output queue.
	typedef struct packed {
		logic signed [RES_W-1:0] value;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic                    last;
	} res_t;

endpackage

>>> rtl/core/conv2d_8x8_valid_core.sv
// Top level of the streaming 8x8 valid-region convolution core.
// Depends on conv2d_pkg, conv2d_ram, conv2d_cell and conv2d_tree.
//
// The core accepts one item per clock cycle, coefficient loads and pixels
// alike, for as long as the consumer keeps taking results. Each pixel item
// reads the seven line RAMs at its column in the cycle it is accepted and
// writes itself into the RAM of its own row slot in the same cycle; the
// next cycle the 8x8 row of cells shifts left by one column and takes the
// new column in. Every cell multiplies its window pixel by its coefficient,
// and a pipelined adder tree with one register per level (six levels for
// an 8x8 kernel) sums the 64 products. A result passes the line RAM read,
// the stage 1 registers, the window cells, the product registers and the
// tree levels before it enters the output queue, which holds sixteen results;
// item_ready drops only when sixteen results are in flight or waiting,
// which a consumer that takes one result per cycle never causes. The line
// RAMs are not cleared after reset, since only rows of the current frame
// feed a result, so the core is ready as soon as reset is released.
// Coefficient loads travel down the same path as pixels and update the
// kernel in order, so a load affects exactly the pixels accepted after it.
// A write on cfg_we sets the image size at once, held between KERNEL_SIZE and
// MAX_SIZE; write it only while no items are in flight.
module conv2d_8x8_valid_core import conv2d_pkg::*; #(
	parameter int MAX_SIZE    = MAX_SIZE_DEF,
	parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration: image size.
	input  logic                    cfg_we,
	input  logic [SIZE_W-1:0]       cfg_data,
	// Input items.
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic                    op,
	input  logic [IDX_W-1:0]        coef_index,
	input  logic signed [VAL_W-1:0] value,
	// Result items.
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic signed [RES_W-1:0] result_value,
	output logic [POS_W-1:0]        out_row,
	output logic [POS_W-1:0]        out_col,
	output logic                    last
);

	localparam int KTAPS    = KERNEL_SIZE * KERNEL_SIZE;
	localparam int LROWS    = KERNEL_SIZE - 1;
	localparam int CNT_W    = $clog2(MAX_SIZE);
	localparam int RM_W     = (LROWS > 1) ? $clog2(LROWS) : 1;
	localparam int TREE_LVL = $clog2(KTAPS);
	localparam int TAG_D    = TREE_LVL + 2;
	localparam int FIFO_D   = 2 ** $clog2(TREE_LVL + 6);
	localparam int PTR_W    = $clog2(FIFO_D);

	localparam logic [CNT_W-1:0] LROWS_C = CNT_W'(LROWS);

	// Last row/column index for a requested size, held inside the legal range.
	function automatic logic [CNT_W-1:0] clamp_last(input logic [SIZE_W-1:0] sz);
		logic [CNT_W-1:0] res;
		if (32'(sz) < KERNEL_SIZE) begin
			res = CNT_W'(KERNEL_SIZE - 1);
		end else if (32'(sz) > MAX_SIZE) begin
			res = CNT_W'(MAX_SIZE - 1);
		end else begin
			res = CNT_W'(sz - SIZE_W'(1));
		end
		return res;
	endfunction

	// Position counters and the line slot of the current row.
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic [RM_W-1:0]  rm_q;

	logic item_acc;
	logic pix_acc;
	logic coef_acc;
	logic in_window;
	logic wrap_col;
	logic wrap_row;

	// Stage 1: line RAM data is valid, the window takes the new column.
	logic                    pix_s1;
	logic                    coef_s1;
	logic signed [VAL_W-1:0] px_s1;
	logic [IDX_W-1:0]        cidx_s1;
	logic [RM_W-1:0]         rm_s1;
	tag_t                    tag_s1;
	tag_t                    tag_pipe_q [TAG_D];

	logic [VAL_W-1:0]         rd_data  [LROWS];
	logic signed [VAL_W-1:0]  new_col  [KERNEL_SIZE];
	logic signed [VAL_W-1:0]  win_val  [KTAPS];
	logic signed [PROD_W-1:0] prod     [KTAPS];
	cell_ctl_t                cell_ctl [KTAPS];
	logic signed [RES_W-1:0]  tree_sum;

	// Output queue and the count of results owed to the consumer.
	res_t             fifo_q [FIFO_D];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic [PTR_W:0]   owed_q;
	logic             push;
	logic             pop;

	// ---------------------------------------------------------------
	// Accept and position tracking
	// ---------------------------------------------------------------
	assign item_acc  = item_valid && item_ready;
	assign pix_acc   = item_acc && (op == OP_PIXEL);
	assign coef_acc  = item_acc && (op == OP_COEF);
	assign in_window = (row_q >= LROWS_C) && (col_q >= LROWS_C);
	// Counters left beyond a smaller size wrap on their next advance.
	assign wrap_col  = col_q >= last_q;
	assign wrap_row  = row_q >= last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= clamp_last(SIZE_W'(IMG_SIZE_RST));
		end else if (cfg_we) begin
			last_q <= clamp_last(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rm_q  <= '0;
		end else if (pix_acc) begin
			if (wrap_col) begin
				col_q <= '0;
				if (wrap_row) begin
					row_q <= '0;
					rm_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					rm_q  <= (rm_q == RM_W'(LROWS - 1)) ? '0 : rm_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Line RAMs: slot rm_q takes the pixel, all slots are read at col_q.
	// The read returns the old contents, so slot rm_q still gives the row
	// seven above the current one.
	// ---------------------------------------------------------------
	for (genvar s = 0; s < LROWS; s++) begin : g_line
		conv2d_ram #(
			.WIDTH (VAL_W),
			.DEPTH (MAX_SIZE)
		) u_line (
			.clk   (clk),
			.we    (pix_acc && (rm_q == RM_W'(s))),
			.waddr (col_q),
			.wdata (value),
			.raddr (col_q),
			.rdata (rd_data[s])
		);
	end

	// ---------------------------------------------------------------
	// Stage 1 registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1  <= 1'b0;
			coef_s1 <= 1'b0;
			tag_s1  <= '0;
		end else begin
			pix_s1      <= pix_acc;
			coef_s1     <= coef_acc;
			tag_s1.emit <= pix_acc && in_window;
			tag_s1.row  <= POS_W'(row_q - LROWS_C);
			tag_s1.col  <= POS_W'(col_q - LROWS_C);
			tag_s1.last <= (row_q == last_q) && (col_q == last_q);
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= value;
		cidx_s1 <= coef_index;
		rm_s1   <= rm_q;
	end

	// Window row r takes line slot (rm + r) mod LROWS: row 0 is the oldest
	// row, and the bottom row takes the pixel itself.
	always_comb begin
		logic [RM_W:0]   slot_sum;
		logic [RM_W-1:0] slot;
		slot_sum = '0;
		slot     = '0;
		for (int r = 0; r < LROWS; r++) begin
			slot_sum = {1'b0, rm_s1} + (RM_W + 1)'(r);
			if (slot_sum >= (RM_W + 1)'(LROWS)) begin
				slot_sum = slot_sum - (RM_W + 1)'(LROWS);
			end
			slot       = slot_sum[RM_W-1:0];
			new_col[r] = $signed(rd_data[slot]);
		end
		new_col[KERNEL_SIZE-1] = px_s1;
	end

	// ---------------------------------------------------------------
	// Row of cells: each cell hands its pixel to its left neighbor.
	// ---------------------------------------------------------------
	for (genvar r = 0; r < KERNEL_SIZE; r++) begin : g_row
		for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_col
			localparam int K = r * KERNEL_SIZE + c;
			logic signed [VAL_W-1:0] din;

			if (c == KERNEL_SIZE - 1) begin : g_edge
				assign din = new_col[r];
			end else begin : g_link
				assign din = win_val[K + 1];
			end

			assign cell_ctl[K].shift   = pix_s1;
			assign cell_ctl[K].coef_we = coef_s1 && (32'(cidx_s1) == K);
			assign cell_ctl[K].coef    = px_s1;

			conv2d_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl[K]),
				.din    (din),
				.dout   (win_val[K]),
				.prod   (prod[K])
			);
		end
	end

	conv2d_tree #(
		.N (KTAPS)
	) u_tree (
		.clk  (clk),
		.prod (prod),
		.sum  (tree_sum)
	);

	// Position tags follow the products through the tree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAG_D; i++) begin
				tag_pipe_q[i] <= '0;
			end
		end else begin
			tag_pipe_q[0] <= tag_s1;
			for (int i = 1; i < TAG_D; i++) begin
				tag_pipe_q[i] <= tag_pipe_q[i-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Output queue. item_ready is held low once every queue entry is
	// promised to a result, so the queue never overflows.
	// ---------------------------------------------------------------
	assign push = tag_pipe_q[TAG_D-1].emit;
	assign pop  = res_valid && res_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].value <= tree_sum;
			fifo_q[wr_ptr_q].row   <= tag_pipe_q[TAG_D-1].row;
			fifo_q[wr_ptr_q].col   <= tag_pipe_q[TAG_D-1].col;
			fifo_q[wr_ptr_q].last  <= tag_pipe_q[TAG_D-1].last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			owed_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
			owed_q <= owed_q + (PTR_W + 1)'(pix_acc && in_window) - (PTR_W + 1)'(pop);
		end
	end

	assign item_ready   = owed_q < (PTR_W + 1)'(FIFO_D);
	assign res_valid    = fill_q != '0;
	assign result_value = fifo_q[rd_ptr_q].value;
	assign out_row      = fifo_q[rd_ptr_q].row;
	assign out_col      = fifo_q[rd_ptr_q].col;
	assign last         = fifo_q[rd_ptr_q].last;

endmodule

>>> rtl/core/conv2d_ram.sv
// Generic simple dual-port RAM with a registered, read-first read port.
// Depends on conv2d_pkg for its default sizes.
module conv2d_ram import conv2d_pkg::*; #(
	parameter int WIDTH = VAL_W,
	parameter int DEPTH = MAX_SIZE_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/conv2d_cell.sv
// One window cell: a window pixel, its kernel coefficient and their product.
// Depends on conv2d_pkg for widths and the cell control struct.
module conv2d_cell import conv2d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [VAL_W-1:0]  din,
	output logic signed [VAL_W-1:0]  dout,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [VAL_W-1:0]  win_q;
	logic signed [VAL_W-1:0]  coef_q;
	logic signed [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= din;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.coef_we) begin
			coef_q <= $signed(ctl.coef);
		end
		prod_s3 <= win_q * coef_q;
	end

	assign dout = win_q;
	assign prod = prod_s3;

endmodule

>>> rtl/core/conv2d_tree.sv
// Pipelined binary adder tree, one register level per level of pairwise additions.
// Depends on conv2d_pkg for product and result widths.
module conv2d_tree import conv2d_pkg::*; #(
	parameter int N = KTAPS_DEF
) (
	input  logic                     clk,
	input  logic signed [PROD_W-1:0] prod [N],
	output logic signed [RES_W-1:0]  sum
);

	localparam int LVL = $clog2(N);
	localparam int P   = 2 ** LVL;

	logic signed [RES_W-1:0] leaf   [P];
	logic signed [RES_W-1:0] node_q [P-1];

	// Leaves beyond N are padding and read as zero.
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_real
			assign leaf[i] = RES_W'(prod[i]);
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	// Heap order: node i sums nodes 2i+1 and 2i+2; the last level reads leaves.
	for (genvar i = 0; i < P - 1; i++) begin : g_node
		if (2 * i + 1 >= P - 1) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[i] <= leaf[2 * i + 1 - (P - 1)] + leaf[2 * i + 2 - (P - 1)];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[i] <= node_q[2 * i + 1] + node_q[2 * i + 2];
			end
		end
	end

	assign sum = node_q[0];

endmodule

>>> rtl/core/conv2d_chk.sv
// Port-level checker for the convolution core, bound to its top level.
// Depends on conv2d_pkg and conv2d_8x8_valid_core_macros.svh.
`include "conv2d_8x8_valid_core_macros.svh"

module conv2d_chk import conv2d_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic signed [RES_W-1:0] result_value,
	input logic [POS_W-1:0]        out_row,
	input logic [POS_W-1:0]        out_col,
	input logic                    last
);

	logic [POS_W-1:0] prev_col_q;
	logic             seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_col_q <= '0;
			seen_q     <= 1'b0;
		end else if (res_valid && res_ready) begin
			prev_col_q <= out_col;
			seen_q     <= 1'b1;
		end
	end

	// A result on offer stays on offer until it is taken.
	`C2D_CHECK_CORE(a_res_hold, res_valid && !res_ready |=> res_valid, "result withdrawn")

	// A stalled result keeps its payload.
	`C2D_CHECK_CORE(a_res_stable, res_valid && !res_ready |=> $stable(result_value) && $stable(out_row) && $stable(out_col) && $stable(last), "stalled result changed")

	// Only an accepted item can use up the output queue's room.
	`C2D_CHECK_CORE(a_ready_fall, $fell(item_ready) |-> $past(item_valid && item_ready), "ready dropped without an accepted item")

	// Results walk the columns in order: next column, or back to the first.
	`C2D_CHECK_CORE(a_col_order, res_valid && res_ready && seen_q |-> out_col == prev_col_q + 1'b1 || out_col == '0, "result column out of order")

endmodule

bind conv2d_8x8_valid_core conv2d_chk u_chk (.*);
